// ----- rtl/bfc_pkg.sv -----
// Package for the border frame compositor: field widths, register indexes, helpers.
`timescale 1ns / 1ps
`default_nettype none
package bfc_pkg;
  localparam int unsigned VP_W   = 13;
  localparam int unsigned GS_W   = 11;
  localparam int unsigned CV_W   = 12;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned GIDX_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_VP_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VP_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VP_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAME_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAME_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERLAY = 3'd6;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_COMP = 1'b1;

  typedef struct packed {
    logic signed [VP_W-1:0] vp_left;
    logic signed [VP_W-1:0] vp_top;
    logic [VP_W-1:0]        vp_cols;
    logic [VP_W-1:0]        vp_rows;
    logic [GS_W-1:0]        game_cols;
    logic [GS_W-1:0]        game_rows;
    logic                   underlay;
  } cfg_t;

  // one division request handed to the scaler
  typedef struct packed {
    logic            start;
    logic [23:0]     num_x;
    logic [VP_W-1:0] den_x;
    logic [23:0]     num_y;
    logic [VP_W-1:0] den_y;
  } div_req_t;

  // x/255 for x <= 255*255: exact through (x + 1 + (x >> 8)) >> 8
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] dst,
                                             input logic [PIX_W-1:0] src);
    logic [7:0]  a, inv, r, g, b, oa;
    logic [15:0] sr, sg, sb;
    a   = src[31:24];
    inv = 8'd255 - a;
    sr  = {8'd0, src[23:16]} * {8'd0, a} + {8'd0, dst[23:16]} * {8'd0, inv};
    sg  = {8'd0, src[15:8]} * {8'd0, a} + {8'd0, dst[15:8]} * {8'd0, inv};
    sb  = {8'd0, src[7:0]} * {8'd0, a} + {8'd0, dst[7:0]} * {8'd0, inv};
    r   = div255(sr);
    g   = div255(sg);
    b   = div255(sb);
    oa  = a + div255({8'd0, dst[31:24]} * {8'd0, inv});
    if (a == 8'hFF) return src;
    if (a == 8'h00) return dst;
    return {oa, r, g, b};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/bfc_div.sv -----
// Restoring divider: two quotients (column and row) side by side with a shared step counter, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module bfc_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bfc_pkg::div_req_t req,
  output logic                  done,
  output logic [10:0]           qx,
  output logic [10:0]           qy
);
  import bfc_pkg::*;
  // quotient < game size <= 2047 so 11 bits; numerator < 2^24
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [23:0]      nx_r, nx_nxt, ny_r, ny_nxt;
  logic [VP_W-1:0]  dx_r, dy_r;
  logic [VP_W:0]    rx_r, rx_nxt, ry_r, ry_nxt;
  logic [VP_W+1:0]  tx, ty;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    nx_nxt   = nx_r;
    ny_nxt   = ny_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    tx = {rx_r, nx_r[23]};
    ty = {ry_r, ny_r[23]};
    done = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      nx_nxt   = req.num_x;
      ny_nxt   = req.num_y;
      rx_nxt   = '0;
      ry_nxt   = '0;
    end else if (busy_r) begin
      if (tx >= {2'b0, dx_r}) begin
        rx_nxt = (VP_W+1)'(tx - {2'b0, dx_r});
        nx_nxt = {nx_r[22:0], 1'b1};
      end else begin
        rx_nxt = tx[VP_W:0];
        nx_nxt = {nx_r[22:0], 1'b0};
      end
      if (ty >= {2'b0, dy_r}) begin
        ry_nxt = (VP_W+1)'(ty - {2'b0, dy_r});
        ny_nxt = {ny_r[22:0], 1'b1};
      end else begin
        ry_nxt = ty[VP_W:0];
        ny_nxt = {ny_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign qx = nx_nxt[10:0];
  assign qy = ny_nxt[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    if (req.start) begin
      dx_r <= req.den_x;
      dy_r <= req.den_y;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bfc_frame_mem.sv -----
// Game frame store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bfc_frame_mem #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/border_frame_compositor.sv -----
// Top level of the border frame compositor: control sequencer, config registers, output stage.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  in_     | in  | game_index 17, game_pixel 32, canvas_col 12,     | req_type
//          |     | canvas_row 12, border_pixel 32 (105 -> 112 bits)|
//  out_    | out | out_pixel 32                                    | from_game
//  cfg_    | in  | wr_en, idx 3, data 13                           | -
//
// Load beats go to the memory write port; the sequencer stays idle.
// Composite beats inside the viewport pass the bit-serial scaler (24 quotient
// bits), then the address multiply, memory read and blend.
// Composite beats outside the viewport go straight to the output stage.
// Reset (rst_n low, synchronous) clears control state; the frame store is
// undefined until written. out_tvalid holds until out_tready; a new beat is
// taken only once the output register is free or being drained.
// GAME_DEPTH must be a power of two (not enforced); store addresses wrap by dropping high bits.
`timescale 1ns / 1ps
`default_nettype none
module border_frame_compositor #(
  parameter int unsigned GAME_DEPTH = 131072,
  parameter int unsigned CANVAS_MAX = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [111:0]   in_tdata,  // game_index, game_pixel, canvas_col, canvas_row, border_pixel
  input  wire logic           in_tuser,  // req_type
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [31:0]         out_tdata, // out_pixel
  output logic                out_tuser, // from_game
  input  wire logic           cfg_wr_en,
  input  wire logic [bfc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bfc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bfc_pkg::*;
  localparam int unsigned AW = (GAME_DEPTH > 1) ? $clog2(GAME_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  cfg_t cfg_r;
  logic [2:0] st_r, st_nxt;

  // input fields
  logic [GIDX_W-1:0] f_gidx;
  logic [31:0]       f_gpix, f_border;
  logic [CV_W-1:0]   f_col, f_row;
  assign f_gidx   = in_tdata[16:0];
  assign f_gpix   = in_tdata[48:17];
  assign f_col    = in_tdata[60:49];
  assign f_row    = in_tdata[72:61];
  assign f_border = in_tdata[104:73];

  // viewport test
  logic signed [VP_W+1:0] vx, vy;
  logic in_vp;
  assign vx = $signed({3'b0, f_col}) -
              $signed({{2{cfg_r.vp_left[VP_W-1]}}, cfg_r.vp_left});
  assign vy = $signed({3'b0, f_row}) -
              $signed({{2{cfg_r.vp_top[VP_W-1]}}, cfg_r.vp_top});
  always_comb begin
    in_vp = (cfg_r.vp_cols != '0) && (cfg_r.vp_rows != '0) &&
            (cfg_r.game_cols != '0) && (cfg_r.game_rows != '0) &&
            (32'(f_col) < CANVAS_MAX) && (32'(f_row) < CANVAS_MAX) &&
            !vx[VP_W+1] && !vy[VP_W+1] &&
            (vx[VP_W:0] < {1'b0, cfg_r.vp_cols}) && (vy[VP_W:0] < {1'b0, cfg_r.vp_rows});
  end

  logic acc;
  assign in_tready = (st_r == ST_IDLE) && (!out_tvalid || out_tready);
  assign acc = in_tvalid && in_tready;

  div_req_t dreq;
  logic ddone;
  logic [10:0] qx, qy;
  always_comb begin
    dreq.start = acc && (in_tuser == REQ_COMP) && in_vp;
    dreq.num_x = {11'd0, vx[VP_W-1:0]} * {13'd0, cfg_r.game_cols};
    dreq.den_x = cfg_r.vp_cols;
    dreq.num_y = {11'd0, vy[VP_W-1:0]} * {13'd0, cfg_r.game_rows};
    dreq.den_y = cfg_r.vp_rows;
  end
  bfc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .qx(qx), .qy(qy));

  logic [10:0] sx_r, sy_r;
  logic [21:0] addr_r;
  logic [31:0] border_r, rdata;
  logic        drawn_r;

  bfc_frame_mem #(.DEPTH(GAME_DEPTH), .AW(AW)) u_mem (
    .clk(clk),
    .we(acc && (in_tuser == REQ_LOAD)),
    .waddr(AW'(f_gidx)),
    .wdata(f_gpix),
    .re(st_r == ST_READ),
    .raddr(AW'(addr_r)),
    .rdata(rdata)
  );

  logic [31:0] game, res;
  always_comb begin
    game = drawn_r ? rdata : 32'd0;
    if (cfg_r.underlay) res = drawn_r ? game : border_r;
    else res = blend(game, border_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (acc && in_tuser == REQ_COMP) st_nxt = in_vp ? ST_DIV : ST_OUT;
      ST_DIV:  if (ddone) st_nxt = ST_ADDR;
      ST_ADDR: st_nxt = ST_READ;
      ST_READ: st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cfg_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_VP_LEFT:   cfg_r.vp_left  <= cfg_data;
          REG_VP_TOP:    cfg_r.vp_top   <= cfg_data;
          REG_VP_COLS:   cfg_r.vp_cols  <= cfg_data;
          REG_VP_ROWS:   cfg_r.vp_rows  <= cfg_data;
          REG_GAME_COLS: cfg_r.game_cols <= cfg_data[GS_W-1:0];
          REG_GAME_ROWS: cfg_r.game_rows <= cfg_data[GS_W-1:0];
          REG_UNDERLAY:  cfg_r.underlay <= cfg_data[0];
          default: ;
        endcase
      end
      if (st_r == ST_OUT) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
    if (acc) begin
      border_r <= f_border;
      drawn_r  <= in_vp;
    end
    if (ddone) begin
      sx_r <= qx;
      sy_r <= qy;
    end
    if (st_r == ST_ADDR)
      addr_r <= {11'd0, sy_r} * {11'd0, cfg_r.game_cols} + {11'd0, sx_r};
    if (st_r == ST_OUT) begin
      out_tdata <= res;
      out_tuser <= drawn_r;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bfc_checker.sv -----
// Port-level checker for the border frame compositor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");
  a_busy_after_comp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken while composite in flight");
  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind border_frame_compositor bfc_checker u_bfc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire

// ----- tb/sv/tb_border_frame_compositor.sv -----
// Testbench for the border frame compositor: loads, composites, config sweeps, stalls.
`timescale 1ns / 1ps
`default_nettype none
module tb_border_frame_compositor;
  import bfc_pkg::*;

  localparam int DEPTH = 131072;
  localparam int CMAX  = 4096;
  localparam int IDLE_LIMIT = 20000;

  // one input beat, unpacked
  typedef struct {
    logic              req;
    logic [GIDX_W-1:0] gidx;
    logic [PIX_W-1:0]  gpix;
    logic [CV_W-1:0]   ccol;
    logic [CV_W-1:0]   crow;
    logic [PIX_W-1:0]  bpix;
  } beat_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             drawn;
  } canvas_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;   // game_index 17, game_pixel 32, canvas_col 12, canvas_row 12, border_pixel 32
  logic in_tuser = 1'b0;         // req_type
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;        // out_pixel
  logic out_tuser;               // from_game
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  border_frame_compositor dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers and frame store
  logic signed [VP_W-1:0] m_left, m_top;
  logic [VP_W-1:0] m_vcols, m_vrows;
  logic [GS_W-1:0] m_gcols, m_grows;
  logic m_under;
  logic [PIX_W-1:0] frame_store [int];

  beat_t pending_beats[$];
  canvas_px_t expected_px[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 38, recv_idle_pct = 73;
  bit hold_recv = 1'b0;
  bit done = 1'b0;

  function automatic logic [PIX_W-1:0] alpha_over(logic [PIX_W-1:0] d, logic [PIX_W-1:0] s);
    int a, inv, r, g, b, oa;
    a = s[31:24];
    inv = 255 - a;
    if (a == 255) return s;
    if (a == 0) return d;
    r  = (s[23:16] * a + d[23:16] * inv) / 255;
    g  = (s[15:8] * a + d[15:8] * inv) / 255;
    b  = (s[7:0] * a + d[7:0] * inv) / 255;
    oa = a + (d[31:24] * inv) / 255;
    return {oa[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  // nearest-neighbour lookup plus blend or underlay; loads update the store and return 0 (no result)
  function automatic bit composite_px(beat_t bt, output canvas_px_t px);
    longint vx, vy, sx, sy, addr;
    logic [PIX_W-1:0] gp;
    gp = '0;
    px.drawn = 1'b0;
    if (bt.req == REQ_LOAD) begin
      frame_store[int'(bt.gidx) % DEPTH] = bt.gpix;
      return 0;
    end
    vx = longint'(bt.ccol) - longint'(m_left);
    vy = longint'(bt.crow) - longint'(m_top);
    if (m_vcols != 0 && m_vrows != 0 && m_gcols != 0 && m_grows != 0 &&
        vx >= 0 && vy >= 0 && vx < m_vcols && vy < m_vrows) begin
      sx = (vx * m_gcols) / m_vcols;
      sy = (vy * m_grows) / m_vrows;
      addr = (sy * m_gcols + sx) % DEPTH;
      if (frame_store.exists(int'(addr))) gp = frame_store[int'(addr)];
      px.drawn = 1'b1;
    end
    if (m_under) px.pix = px.drawn ? gp : bt.bpix;
    else px.pix = alpha_over(px.drawn ? gp : '0, bt.bpix);
    return 1;
  endfunction

  // driver: one beat per handshake, valid held while the beat waits
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_t bt;
          canvas_px_t px;
          bt = pending_beats.pop_front();
          if (composite_px(bt, px)) expected_px.push_back(px);
          in_tvalid <= 1'b1;
          in_tuser  <= bt.req;
          in_tdata  <= {7'd0, bt.bpix, bt.crow, bt.ccol, bt.gpix, bt.gidx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready, long hold when asked
  always @(posedge clk) begin
    if (rst_n) out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat pix=%h game=%b", out_tdata, out_tuser);
      end else begin
        canvas_px_t e;
        e = expected_px.pop_front();
        if (out_tdata !== e.pix || out_tuser !== e.drawn) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pix=%h game=%b got pix=%h game=%b",
                     e.pix, e.drawn, out_tdata, out_tuser);
        end
      end
    end
  end

  // watchdog on handshake-free cycles
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !done) begin
      $display("tb: failure");
      $finish;
    end
  end

  // register write during idle time; predictor updated in step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    case (idx)
      REG_VP_LEFT:   m_left  = val;
      REG_VP_TOP:    m_top   = val;
      REG_VP_COLS:   m_vcols = val;
      REG_VP_ROWS:   m_vrows = val;
      REG_GAME_COLS: m_gcols = val[GS_W-1:0];
      REG_GAME_ROWS: m_grows = val[GS_W-1:0];
      REG_UNDERLAY:  m_under = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_layout(int l, int t, int vc, int vr, int gc, int gr, bit u);
    write_reg(REG_VP_LEFT, l[12:0]);
    write_reg(REG_VP_TOP, t[12:0]);
    write_reg(REG_VP_COLS, vc[12:0]);
    write_reg(REG_VP_ROWS, vr[12:0]);
    write_reg(REG_GAME_COLS, gc[12:0]);
    write_reg(REG_GAME_ROWS, gr[12:0]);
    write_reg(REG_UNDERLAY, {12'd0, u});
  endtask

  // wait until all beats are out and results home, then idle on so the last loads settle
  task automatic drain();
    while (pending_beats.size() > 0 || in_tvalid || expected_px.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_load(int idx, logic [31:0] p);
    beat_t bt;
    bt = '{REQ_LOAD, idx[16:0], p, CV_W'($urandom), CV_W'($urandom), PIX_W'($urandom)};
    pending_beats.push_back(bt);
  endtask

  task automatic push_comp(int c, int r, logic [31:0] b);
    beat_t bt;
    bt = '{REQ_COMP, GIDX_W'($urandom), PIX_W'($urandom), c[11:0], r[11:0], b};
    pending_beats.push_back(bt);
  endtask

  // fill the whole gc x gr frame so every lookup hits a written entry
  task automatic fill_frame(int gc, int gr);
    for (int i = 0; i < gc * gr; i++) push_load(i, $urandom);
  endtask

  // composites mostly near the viewport, some anywhere on the canvas
  task automatic random_comps(int n, int l, int t, int vc, int vr);
    int c, r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) begin
        c = l + $urandom_range(vc + 3) - 2;
        r = t + $urandom_range(vr + 3) - 2;
        c = (c < 0) ? 0 : (c > CMAX - 1) ? CMAX - 1 : c;
        r = (r < 0) ? 0 : (r > CMAX - 1) ? CMAX - 1 : r;
      end else begin
        c = $urandom_range(CMAX - 1);
        r = $urandom_range(CMAX - 1);
      end
      case ($urandom_range(5))
        0: push_comp(c, r, {8'hFF, 24'($urandom)});
        1: push_comp(c, r, {8'h00, 24'($urandom)});
        default: push_comp(c, r, $urandom);
      endcase
    end
  endtask

  initial begin
    int l, t, vc, vr, gc, gr;
    m_left = 0; m_top = 0; m_vcols = 0; m_vrows = 0;
    m_gcols = 0; m_grows = 0; m_under = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config means no viewport, border over zero
    push_comp(0, 0, 32'h80FF_FFFF);
    push_comp(CMAX - 1, CMAX - 1, 32'hFFFF_FFFF);
    push_comp(5, 5, 32'h0000_0000);
    drain();

    // small frame, viewport at the origin; load extremes then composites
    set_layout(0, 0, 8, 8, 4, 4, 1'b0);
    push_load(0, 32'hFFFF_FFFF);
    push_load(1, 32'h0000_0000);
    for (int i = 2; i < 16; i++) push_load(i, $urandom);
    push_load(DEPTH - 1, 32'hA5A5_5A5A);                // top store address
    push_comp(0, 0, 32'hFF12_3456);                     // opaque border
    push_comp(1, 0, 32'h00AB_CDEF);                     // transparent border
    push_comp(2, 3, 32'h7F80_8080);                     // partial alpha
    push_comp(7, 7, 32'h01FF_FFFF);                     // last viewport pixel
    push_comp(8, 7, 32'hFEFF_FFFF);                     // just outside right
    push_comp(7, 8, 32'h40C0_C0C0);                     // just outside bottom
    drain();
    write_reg(REG_UNDERLAY, 13'd1);                     // game replaces border
    push_comp(3, 3, 32'h8011_2233);
    push_comp(9, 1, 32'h8011_2233);
    drain();

    // negative origin, wide viewport: large scaler numerators
    set_layout(-4095, -4095, 4096, 4096, 1024, 1, 1'b0);
    push_load(1023, $urandom);                          // column 1023, row 0
    push_comp(0, 0, $urandom);
    push_comp(CMAX - 1, CMAX - 1, $urandom);
    drain();
    set_layout(4095, 4095, 1, 1, 1, 1024, 1'b1);
    push_load(0, $urandom);
    push_comp(CMAX - 1, CMAX - 1, $urandom);
    push_comp(CMAX - 2, CMAX - 1, $urandom);
    drain();
    write_reg(REG_GAME_COLS, 13'd0);
    push_comp(CMAX - 1, CMAX - 1, $urandom);
    drain();

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 73; recv_idle_pct = 38; end
      if (ph == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      gc = $urandom_range(1, 8);
      gr = $urandom_range(1, 8);
      vc = $urandom_range(1, 40);
      vr = $urandom_range(1, 40);
      l  = $urandom_range(8191) - 4096;
      t  = $urandom_range(8191) - 4096;
      if ($urandom_range(1)) begin l = $urandom_range(100); t = $urandom_range(100); end
      set_layout(l, t, vc, vr, gc, gr, $urandom_range(1));
      fill_frame(gc, gr);
      random_comps(24, l, t, vc, vr);
      // rewrite some pixels mid-stream
      for (int i = 0; i < 4; i++) push_load($urandom_range(gc * gr - 1), $urandom);
      random_comps(12, l, t, vc, vr);
      if (ph == 7) begin
        // long receiver hold while the sender keeps offering beats
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      drain();
    end

    done = 1'b1;
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- border_frame_compositor.f -----
rtl/bfc_pkg.sv
rtl/bfc_div.sv
rtl/bfc_frame_mem.sv
rtl/border_frame_compositor.sv
rtl/bfc_checker.sv
tb/sv/tb_border_frame_compositor.sv
